// ----- rtl/core/pec_pkg.sv -----
// Shared types and constants for the pulse edge capture FIFO.
// Depends on nothing; imported by pec_ctrl, the top level and the testbench.
package pec_pkg;

	localparam int RING_DEPTH = 512;
	localparam int IDX_W      = $clog2(RING_DEPTH);
	localparam int WIDTH_W    = 16;
	localparam int TIME_W     = 32;

	localparam logic [WIDTH_W-1:0] MIN_PULSE_RESET = 16'd30;
	localparam logic [WIDTH_W-1:0] GAP_SAT         = 16'hFFFF;
	localparam logic [IDX_W-1:0]   IDX_LAST        = IDX_W'(RING_DEPTH - 1);

	typedef enum logic [1:0] {
		CMD_EDGE  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_START = 2'd2
	} cmd_e_t;

	typedef enum logic [2:0] {
		ST_STORED  = 3'd0,
		ST_FULL    = 3'd1,
		ST_SHORT   = 3'd2,
		ST_POPPED  = 3'd3,
		ST_EMPTY   = 3'd4,
		ST_STARTED = 3'd5
	} status_e_t;

	typedef struct packed {
		logic               level;
		logic [WIDTH_W-1:0] width;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
	} mem_req_t;

	typedef struct packed {
		logic      valid;
		logic      pend;
		status_e_t status;
	} ctrl_res_t;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
		ring_next = (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
	endfunction

endpackage

// ----- rtl/core/pec_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM with a registered read.
// No package dependency.
module pec_ram #(
	parameter int DATA_W = 17,
	parameter int DEPTH  = 512,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/core/pec_ctrl.sv -----
// Ring pointers, edge timing and drop decisions for the capture FIFO.
// Depends on pec_pkg; drives the ring RAM request and the per-beat result.
module pec_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [1:0]                command,
	input  logic [pec_pkg::TIME_W-1:0]  now_us,
	input  logic                      pin_level,
	input  logic [pec_pkg::WIDTH_W-1:0] min_pulse_us,
	output pec_pkg::mem_req_t         mem_req,
	output pec_pkg::ctrl_res_t        res
);
	import pec_pkg::*;

	logic [IDX_W-1:0]  head_q, tail_q, head_d, tail_d;
	logic [TIME_W-1:0] last_q, last_d;
	logic              held_q, held_d;
	logic [TIME_W-1:0] gap;
	logic [WIDTH_W-1:0] gap_sat;
	logic [IDX_W-1:0]  head_nxt;

	assign gap      = now_us - last_q;
	assign gap_sat  = (|gap[TIME_W-1:WIDTH_W]) ? GAP_SAT : gap[WIDTH_W-1:0];
	assign head_nxt = ring_next(head_q);

	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		last_d  = last_q;
		held_d  = held_q;
		mem_req = '0;
		mem_req.wr_addr = head_q;
		mem_req.wr_data = '{level: held_q, width: gap_sat};
		mem_req.rd_addr = tail_q;
		res = '{valid: 1'b0, pend: 1'b0, status: ST_STORED};
		if (accept) begin
			case (cmd_e_t'(command))
				CMD_EDGE: begin
					res.valid = 1'b1;
					last_d    = now_us;
					if (head_nxt == tail_q) begin
						res.status = ST_FULL;
					end else if (gap_sat < min_pulse_us) begin
						res.status = ST_SHORT;
					end else begin
						res.status    = ST_STORED;
						mem_req.wr_en = 1'b1;
						held_d        = pin_level;
						head_d        = head_nxt;
					end
				end
				CMD_POP: begin
					res.valid = 1'b1;
					if (head_q == tail_q) begin
						res.status = ST_EMPTY;
					end else begin
						res.status    = ST_POPPED;
						res.pend      = 1'b1;
						mem_req.rd_en = 1'b1;
						tail_d        = ring_next(tail_q);
					end
				end
				CMD_START: begin
					res.valid  = 1'b1;
					res.status = ST_STARTED;
					last_d     = now_us;
					held_d     = pin_level;
					head_d     = '0;
					tail_d     = '0;
				end
				default: begin
					res.valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			last_q <= '0;
			held_q <= 1'b0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			last_q <= last_d;
			held_q <= held_d;
		end
	end

endmodule

// ----- rtl/core/pulse_edge_capture_fifo.sv -----
// Top level of the pulse edge capture FIFO: stream ports, output register.
// Depends on pec_pkg, pec_ctrl and pec_ram.
//
// Each input beat carries a command (s_tuser) with a microsecond timestamp and
// pin level (s_tdata). A start beat empties the ring and records time and level;
// an edge beat measures the gap since the previous edge, saturates it at 65535
// and stores it with the level held during the pulse, unless the ring is full
// (one of the 512 slots always stays empty) or the gap is below min_pulse_us;
// a pop beat returns the oldest pulse or reports empty. Every command but code 3
// gives one result beat carrying its status on m_tuser; code 3 is taken and
// ignored. Edge, start and empty-pop results go straight to the result
// register; a pop that reads the ring waits for the registered RAM read, and
// s_tready drops while the read is outstanding. The result register
// lets a new beat enter while the previous result is being taken. Ring
// contents need no clearing after reset, only the pointers are reset.
module pulse_edge_capture_fifo (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] now_us, [32] pin_level, [39:33] zero
	input  logic [1:0]  s_tuser,   // [1:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] pulse_us, [16] pulse_level, [23:17] zero
	output logic [2:0]  m_tuser,   // [2:0] status
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data // min_pulse_us
);
	import pec_pkg::*;

	logic               s_accept;
	logic               out_free;
	logic [WIDTH_W-1:0] min_pulse_q;
	logic               pend_s1;
	mem_req_t           mem_req;
	ctrl_res_t          res;
	logic [ENTRY_W-1:0] rd_data;
	entry_t             rd_entry;
	logic               m_valid_q;
	status_e_t          m_status_q;
	entry_t             m_entry_q;

	// Result register is free when empty or being drained this cycle.
	assign out_free = !m_valid_q || m_tready;
	// Hold the input while a ring read is in flight; its result lands next cycle.
	assign s_tready = out_free && !pend_s1;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q <= MIN_PULSE_RESET;
		end else if (cfg_wr_en) begin
			min_pulse_q <= cfg_wr_data;
		end
	end

	pec_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (s_accept),
		.command      (s_tuser),
		.now_us       (s_tdata[31:0]),
		.pin_level    (s_tdata[32]),
		.min_pulse_us (min_pulse_q),
		.mem_req      (mem_req),
		.res          (res)
	);

	pec_ram #(
		.DATA_W (ENTRY_W),
		.DEPTH  (RING_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_req.wr_en),
		.wr_addr (mem_req.wr_addr),
		.wr_data (mem_req.wr_data),
		.rd_en   (mem_req.rd_en),
		.rd_addr (mem_req.rd_addr),
		.rd_data (rd_data)
	);

	assign rd_entry = entry_t'(rd_data);

	// Track the outstanding pop read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= res.valid && res.pend;
		end
	end

	// Result register: load the RAM word for a finished pop, otherwise the
	// immediate status with zero payload; advance when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (pend_s1 || (res.valid && !res.pend)) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			m_status_q <= ST_POPPED;
			m_entry_q  <= rd_entry;
		end else if (res.valid && !res.pend) begin
			m_status_q <= res.status;
			m_entry_q  <= '0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {7'd0, m_entry_q.level, m_entry_q.width};

	// No new beat enters while a ring read is outstanding.
	a_no_accept_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !s_accept)
		else $error("beat accepted during outstanding ring read");

	// An outstanding read always turns into a popped result next cycle.
	a_pend_to_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |=> (m_tvalid && m_tuser == ST_POPPED))
		else $error("ring read did not produce a popped result");

	// Only a popped result carries payload.
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_POPPED) |-> (m_tdata == '0))
		else $error("non-pop result carries payload");

	// A result waiting to be taken is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !(pend_s1 || (res.valid && !res.pend)))
		else $error("result register overwritten while stalled");

endmodule

// ----- dv/pec_checker.sv -----
// Scoreboard for the pulse edge capture FIFO: watches the stream and config ports.
// Predicts one result per accepted command but the unused code and compares it with the output beats.
// Depends on pec_pkg.
module pec_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] now_us, [32] pin_level, [39:33] zero
	input  logic [1:0]  s_tuser,   // [1:0] command
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [15:0] pulse_us, [16] pulse_level, [23:17] zero
	input  logic [2:0]  m_tuser,   // [2:0] status
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	output int          fail_count,
	output int          pending
);
	import pec_pkg::*;

	typedef struct {
		status_e_t          status;
		logic [WIDTH_W-1:0] width;
		logic               level;
	} pulse_result_t;

	logic [WIDTH_W-1:0] gap_mem [RING_DEPTH];
	logic               lvl_mem [RING_DEPTH];
	logic [IDX_W-1:0]   wr_slot;
	logic [IDX_W-1:0]   rd_slot;
	logic [TIME_W-1:0]  prev_edge_us;
	logic               cur_level;
	logic [WIDTH_W-1:0] min_gap_us;
	pulse_result_t      result_q [$];
	pulse_result_t      want;

	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
		return IDX_W'((int'(idx) + 1) % RING_DEPTH);
	endfunction

	task automatic flag_fail(input string what);
		fail_count = fail_count + 1;
		if (fail_count <= 10) begin
			$display("[%0t] %s", $realtime, what);
		end
	endtask

	// Work out the result of one accepted command and queue it.
	task automatic predict_pulse(input logic [1:0] cmd, input logic [TIME_W-1:0] now,
			input logic pin);
		pulse_result_t      r;
		logic [TIME_W-1:0]  span;
		logic [WIDTH_W-1:0] sat;
		r.status = ST_STARTED;
		r.width  = '0;
		r.level  = 1'b0;
		case (cmd)
			CMD_EDGE: begin
				span         = now - prev_edge_us;
				prev_edge_us = now;
				sat          = (span > TIME_W'(GAP_SAT)) ? GAP_SAT : span[WIDTH_W-1:0];
				if (next_slot(wr_slot) == rd_slot) begin
					r.status = ST_FULL;
				end else if (sat < min_gap_us) begin
					r.status = ST_SHORT;
				end else begin
					gap_mem[wr_slot] = sat;
					lvl_mem[wr_slot] = cur_level;
					cur_level        = pin;
					wr_slot          = next_slot(wr_slot);
					r.status         = ST_STORED;
				end
			end
			CMD_POP: begin
				if (wr_slot == rd_slot) begin
					r.status = ST_EMPTY;
				end else begin
					r.width  = gap_mem[rd_slot];
					r.level  = lvl_mem[rd_slot];
					rd_slot  = next_slot(rd_slot);
					r.status = ST_POPPED;
				end
			end
			CMD_START: begin
				prev_edge_us = now;
				cur_level    = pin;
				wr_slot      = '0;
				rd_slot      = '0;
			end
			default: begin
				// unused command code: taken, no result
				return;
			end
		endcase
		result_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot      = '0;
			rd_slot      = '0;
			prev_edge_us = '0;
			cur_level    = 1'b0;
			min_gap_us   = MIN_PULSE_RESET;
			fail_count   = 0;
			result_q.delete();
			pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				min_gap_us = cfg_wr_data;
			end
			if (s_tvalid && s_tready) begin
				predict_pulse(s_tuser, s_tdata[31:0], s_tdata[32]);
			end
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					flag_fail($sformatf("unexpected result beat: status %0d width %0d level %0b",
						m_tuser, m_tdata[15:0], m_tdata[16]));
				end else begin
					want = result_q.pop_front();
					if (m_tuser != want.status || m_tdata[15:0] != want.width
							|| m_tdata[16] != want.level) begin
						flag_fail($sformatf({"result mismatch: expected status %s width %0d ",
							"level %0b, got status %0d width %0d level %0b"},
							want.status.name(), want.width, want.level,
							m_tuser, m_tdata[15:0], m_tdata[16]));
					end
				end
			end
			pending <= result_q.size();
		end
	end

endmodule

// ----- dv/tb_pulse_edge_capture_fifo.sv -----
// Top of the pulse edge capture FIFO testbench: clock, reset, stimulus and verdict.
// Depends on pec_pkg, pec_checker and the block itself.
module tb_pulse_edge_capture_fifo;
	import pec_pkg::*;

	localparam int          CLK_HALF     = 10;
	localparam int          SETTLE       = 8;       // a ring pop waits on the RAM read; leave margin
	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam logic [1:0]  CMD_UNUSED   = 2'd3;    // taken by the block, no result

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        s_tvalid    = 1'b0;
	logic [39:0] s_tdata     = '0;   // [31:0] now_us, [32] pin_level, [39:33] zero
	logic [1:0]  s_tuser     = '0;   // [1:0] command
	logic        m_tready    = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [15:0] cfg_wr_data = '0;   // min_pulse_us
	logic        s_tready;
	logic        m_tvalid;
	logic [23:0] m_tdata;            // [15:0] pulse_us, [16] pulse_level, [23:17] zero
	logic [2:0]  m_tuser;            // [2:0] status

	int          fail_count;
	int          pending;
	int          src_idle_pct   = 0;
	int          sink_stall_pct = 0;
	int unsigned min_now        = 30;   // mirror of min_pulse_us, shapes the gaps
	int unsigned cycles         = 0;
	logic [31:0] stamp          = '0;   // time of the last edge or start sent

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	pulse_edge_capture_fifo dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	pec_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// Receiver: stall at random according to the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// Watchdog: give up long after the slowest correct run would have ended.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("pulse_edge_capture_fifo test failed");
			$finish;
		end
	end

	// Offer one beat, idling first at the phase's rate, and hold it until taken.
	// Valid stays high between back-to-back beats, so it is never dropped and
	// raised in the same step.
	task automatic send_beat(input logic [1:0] cmd, input logic [31:0] now, input logic pin);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {7'd0, pin, now};
		if (cmd == CMD_EDGE || cmd == CMD_START) begin
			stamp = now;
		end
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
	endtask

	task automatic edge_after(input logic [31:0] gap, input logic pin);
		send_beat(CMD_EDGE, stamp + gap, pin);
	endtask

	// Hold the sender off until every expected result has been taken, then let
	// the block settle (an ignored command may still be in flight).
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_min(input logic [15:0] value);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		min_now      = value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Pick a gap: mostly valid pulses, some glitches, the threshold itself,
	// the saturation point and full 32-bit spans that wrap the timestamp.
	function automatic logic [31:0] pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 12 && min_now > 0) begin
			return $urandom_range(0, min_now - 1);
		end
		if (r < 18) begin
			return $urandom();
		end
		if (r < 24) begin
			return min_now;
		end
		if (r < 28) begin
			return 32'(GAP_SAT) + $urandom_range(0, 1);
		end
		return min_now + $urandom_range(0, 3000);
	endfunction

	task automatic random_item(input int edge_pct);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 2) begin
			send_beat(CMD_UNUSED, $urandom(), 1'($urandom_range(0, 1)));
		end else if (r < 5) begin
			send_beat(CMD_START, stamp + pick_gap(), 1'($urandom_range(0, 1)));
		end else if (r < 5 + edge_pct) begin
			edge_after(pick_gap(), 1'($urandom_range(0, 1)));
		end else begin
			send_beat(CMD_POP, $urandom(), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic run_phase(input int n, input int src_pct, input int sink_pct,
			input int edge_pct);
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		repeat (n) random_item(edge_pct);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: edge before any start, pops down to empty, unused code.
		edge_after(32'd100, 1'b1);
		send_beat(CMD_POP, '1, 1'b0);
		send_beat(CMD_POP, '0, 1'b1);
		send_beat(CMD_UNUSED, 32'hA5A5_5A5A, 1'b1);

		// Start just below the wrap so the first gap crosses zero.
		send_beat(CMD_START, 32'hFFFF_FFF0, 1'b1);
		edge_after(32'd32, 1'b0);
		edge_after(32'd29, 1'b1);      // one below the reset minimum: glitch
		edge_after(32'd30, 1'b1);      // exactly the minimum: stored
		edge_after(32'd70000, 1'b0);   // saturates
		edge_after(32'd0, 1'b1);       // zero gap: glitch
		edge_after(32'd65535, 1'b0);   // exactly the saturation point
		repeat (5) send_beat(CMD_POP, $urandom(), 1'b0);
		send_beat(CMD_POP, $urandom(), 1'b1);

		// Largest minimum: only saturated gaps get through.
		write_min(16'hFFFF);
		send_beat(CMD_START, '0, 1'b0);
		edge_after(32'd65534, 1'b1);
		edge_after(32'd65535, 1'b0);
		edge_after(32'hFFFF_FFFF, 1'b1);
		repeat (3) send_beat(CMD_POP, $urandom(), 1'b0);

		// Fill the ring to full with no idling, free one slot, then pop it dry.
		write_min(16'd0);
		send_beat(CMD_START, $urandom(), 1'($urandom_range(0, 1)));
		edge_after(32'd0, 1'b1);
		repeat (RING_DEPTH + 2) edge_after(pick_gap(), 1'($urandom_range(0, 1)));
		send_beat(CMD_POP, $urandom(), 1'b0);
		edge_after(pick_gap(), 1'($urandom_range(0, 1)));
		edge_after(pick_gap(), 1'($urandom_range(0, 1)));
		repeat (RING_DEPTH + 1) send_beat(CMD_POP, $urandom(), 1'($urandom_range(0, 1)));

		// Random phases, each under its own minimum and idling pattern.
		write_min(16'($urandom_range(0, 200)));
		run_phase(150, 0, 0, 55);
		write_min(16'd30);
		run_phase(150, 75, 0, 50);
		write_min(16'($urandom_range(0, 65535)));
		run_phase(75, 0, 75, 50);
		drain();
		run_phase(75, 0, 75, 45);
		write_min(16'($urandom_range(1000, 5000)));
		run_phase(100, 30, 30, 50);

		// Let every expected result drain, then settle and give the verdict.
		drain();
		@(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("pulse_edge_capture_fifo test passed");
		end else begin
			$display("pulse_edge_capture_fifo test failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/pec_pkg.sv
rtl/core/pec_ram.sv
rtl/core/pec_ctrl.sv
rtl/core/pulse_edge_capture_fifo.sv
dv/pec_checker.sv
dv/tb_pulse_edge_capture_fifo.sv
